### src/assert_macros.svh
// Assertion macros shared by the RTL.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define RKB_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Same, active also during reset.
`define RKB_ASSERT_ALWAYS(label, clk, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);
`endif

### src/rkbc_pkg.sv
`timescale 1ns / 1ps
// Package for the range keyed block cache: widths, codes and command types.
// No dependencies.
package rkbc_pkg;
	localparam int ENTRY_COUNT_DEF = 32;
	localparam int BLOCKS_PER_ENTRY_DEF = 4;
	localparam int KEY_W = 40;
	localparam int AGE_W = 48;
	localparam int USERS_W = 8;
	localparam int CMD_W = 2;
	localparam int STATUS_W = 3;
	localparam int ID_W = 5;
	localparam int SUB_W = 2;

	localparam logic [CMD_W-1:0] CMD_GET = 2'd0;
	localparam logic [CMD_W-1:0] CMD_RELEASE = 2'd1;
	localparam logic [CMD_W-1:0] CMD_PIN = 2'd2;

	localparam logic [STATUS_W-1:0] ST_HIT = 3'd0;
	localparam logic [STATUS_W-1:0] ST_ALLOC = 3'd1;
	localparam logic [STATUS_W-1:0] ST_FULL = 3'd2;
	localparam logic [STATUS_W-1:0] ST_COUNT = 3'd3;
	localparam logic [STATUS_W-1:0] ST_UNDER = 3'd4;

	// datapath operation selected by the controller
	typedef enum logic [3:0] {
		OP_NONE,
		OP_LATCH,
		OP_HSCAN,
		OP_VSCAN,
		OP_REMOVE,
		OP_FIND,
		OP_INSERT,
		OP_FINISH,
		OP_CMDCOUNT
	} dp_op_t;

	typedef struct packed {
		dp_op_t op;
	} dp_cmd_t;

	typedef struct packed {
		logic scan_last;
		logic hit_found;
		logic victim_found;
		logic shift_done;
		logic find_done;
	} dp_stat_t;
endpackage

### src/rkbc_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the input and result beats.
// Depends on rkbc_pkg.
interface rkbc_in_if import rkbc_pkg::*; ();
	logic valid;
	logic ready;
	logic [CMD_W-1:0] command;
	logic [7:0] device;
	logic [31:0] block_number;
	logic [4:0] slot;
	modport source(output valid, command, device, block_number, slot, input ready);
	modport sink(input valid, command, device, block_number, slot, output ready);
endinterface

interface rkbc_out_if import rkbc_pkg::*; ();
	logic valid;
	logic ready;
	logic [STATUS_W-1:0] status;
	logic [ID_W-1:0] entry_id;
	logic [SUB_W-1:0] sub_index;
	logic needs_read;
	modport source(output valid, status, entry_id, sub_index, needs_read, input ready);
	modport sink(input valid, status, entry_id, sub_index, needs_read, output ready);
endinterface

### src/rkbc_ctrl.sv
`timescale 1ns / 1ps
// Controller state machine for the block cache.
// Depends on rkbc_pkg.
module rkbc_ctrl import rkbc_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input logic [CMD_W-1:0] in_command,
	output logic out_valid,
	input logic out_ready,
	output dp_cmd_t cmd,
	input dp_stat_t stat
);
	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_HSCAN = 3'd1;
	localparam logic [2:0] S_VSCAN = 3'd2;
	localparam logic [2:0] S_REMOVE = 3'd3;
	localparam logic [2:0] S_FIND = 3'd4;
	localparam logic [2:0] S_INSERT = 3'd5;
	localparam logic [2:0] S_FINISH = 3'd6;
	localparam logic [2:0] S_OUT = 3'd7;

	logic [2:0] state_q, state_d;
	logic out_valid_q;

	assign in_ready = (state_q == S_IDLE) && (!out_valid_q || out_ready);
	assign out_valid = out_valid_q;

	always_comb begin
		state_d = state_q;
		cmd.op = OP_NONE;
		case (state_q)
			S_IDLE: begin
				if (in_valid && in_ready) begin
					cmd.op = OP_LATCH;
					state_d = (in_command == CMD_GET) ? S_HSCAN : S_OUT;
				end
			end
			S_HSCAN: begin
				cmd.op = OP_HSCAN;
				if (stat.hit_found || stat.scan_last)
					state_d = stat.hit_found ? S_FINISH : S_VSCAN;
			end
			S_VSCAN: begin
				cmd.op = OP_VSCAN;
				if (stat.scan_last)
					state_d = S_REMOVE;
			end
			S_REMOVE: begin
				cmd.op = OP_REMOVE;
				if (!stat.victim_found)
					state_d = S_FINISH;
				else if (stat.shift_done)
					state_d = S_FIND;
			end
			S_FIND: begin
				cmd.op = OP_FIND;
				if (stat.find_done)
					state_d = S_INSERT;
			end
			S_INSERT: begin
				cmd.op = OP_INSERT;
				if (stat.shift_done)
					state_d = S_FINISH;
			end
			S_FINISH: begin
				cmd.op = OP_FINISH;
				state_d = S_IDLE;
			end
			S_OUT: begin
				cmd.op = OP_CMDCOUNT;
				state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.op == OP_FINISH || cmd.op == OP_CMDCOUNT)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end
endmodule

### src/rkbc_dp.sv
`timescale 1ns / 1ps
// Datapath: entry tables, sorted order, scan pointers and result register.
// Depends on rkbc_pkg.
module rkbc_dp import rkbc_pkg::*; #(
	parameter int ENTRY_COUNT = ENTRY_COUNT_DEF,
	parameter int BLOCKS_PER_ENTRY = BLOCKS_PER_ENTRY_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic [CMD_W-1:0] in_command,
	input logic [7:0] in_device,
	input logic [31:0] in_block_number,
	input logic [4:0] in_slot,
	input dp_cmd_t cmd,
	output dp_stat_t stat,
	output logic [STATUS_W-1:0] status,
	output logic [ID_W-1:0] entry_id,
	output logic [SUB_W-1:0] sub_index,
	output logic needs_read
);
	localparam int IW = (ENTRY_COUNT > 1) ? $clog2(ENTRY_COUNT) : 1;
	localparam int SPW = $clog2(BLOCKS_PER_ENTRY + 1);
	localparam int LW = BLOCKS_PER_ENTRY;
	localparam int SBW = (BLOCKS_PER_ENTRY > 1) ? $clog2(BLOCKS_PER_ENTRY) : 1;
	localparam logic [IW-1:0] LAST = IW'(ENTRY_COUNT - 1);
	localparam logic [SPW-1:0] SPAN_MAX = SPW'(BLOCKS_PER_ENTRY);
	localparam logic [USERS_W-1:0] USERS_MAX = '1;

	// Per-entry registers; small enough for flip-flops, reset values defined.
	logic [KEY_W-1:0] key_q [ENTRY_COUNT];
	logic [SPW-1:0] span_q [ENTRY_COUNT];
	logic [USERS_W-1:0] users_q [ENTRY_COUNT];
	logic [AGE_W-1:0] age_q [ENTRY_COUNT];
	logic [IW-1:0] order_q [ENTRY_COUNT];
	logic [LW-1:0] loaded_q [ENTRY_COUNT];
	logic [AGE_W-1:0] age_ctr_q;

	logic [CMD_W-1:0] cmd_q;
	logic [KEY_W-1:0] rkey_q;
	logic [4:0] slot_q;
	logic [IW-1:0] ptr_q;
	logic found_q;
	logic [AGE_W-1:0] best_q;
	logic [IW-1:0] vpos_q;
	logic [IW-1:0] hit_q;
	logic [IW-1:0] ins_q;
	logic [STATUS_W-1:0] status_q;
	logic [STATUS_W-1:0] res_st_q;
	logic [ID_W-1:0] id_q;
	logic [SUB_W-1:0] sub_q;
	logic rd_q;

	logic [KEY_W-1:0] diff;
	logic hit_now;
	logic [IW-1:0] vent;
	logic [IW-1:0] fent;
	logic after_now;
	logic [AGE_W-1:0] age_nx;
	logic [IW-1:0] hent;
	logic [SBW-1:0] hsub;
	logic slot_ok;
	logic [IW-1:0] sidx;

	function automatic logic [SPW-1:0] clip(input logic [KEY_W-1:0] from,
			input logic [KEY_W-1:0] to);
		logic [KEY_W-1:0] d;
		begin
			d = to - from;
			clip = (d < KEY_W'(BLOCKS_PER_ENTRY)) ? SPW'(d) : SPAN_MAX;
		end
	endfunction

	assign diff = rkey_q - key_q[ptr_q];
	assign hit_now = (span_q[ptr_q] != '0) && (rkey_q >= key_q[ptr_q])
		&& (diff < KEY_W'(span_q[ptr_q]));
	assign vent = order_q[ptr_q];
	assign fent = order_q[ptr_q];
	assign after_now = (span_q[fent] == '0) || (key_q[fent] > rkey_q);
	assign age_nx = age_ctr_q + AGE_W'(1);
	assign hent = hit_q;
	assign hsub = SBW'(rkey_q - key_q[hent]);
	assign slot_ok = (32'(slot_q) < 32'(ENTRY_COUNT));
	assign sidx = IW'(slot_q);

	assign stat.scan_last = (cmd.op == OP_HSCAN) ? (ptr_q == LAST) : (ptr_q == '0);
	assign stat.hit_found = hit_now;
	assign stat.victim_found = found_q;
	assign stat.shift_done = (cmd.op == OP_REMOVE) ? (ptr_q == LAST) : (ptr_q == ins_q);
	assign stat.find_done = after_now || (ptr_q == IW'(ENTRY_COUNT - 2)) || (ENTRY_COUNT < 2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < ENTRY_COUNT; i++) begin
				key_q[i] <= '0;
				span_q[i] <= '0;
				users_q[i] <= '0;
				age_q[i] <= '0;
				order_q[i] <= IW'(i);
				loaded_q[i] <= '0;
			end
			age_ctr_q <= '0;
			ptr_q <= '0;
			found_q <= 1'b0;
			best_q <= '0;
			vpos_q <= '0;
			hit_q <= '0;
			ins_q <= '0;
		end else begin
			case (cmd.op)
				OP_LATCH: begin
					ptr_q <= '0;
					found_q <= 1'b0;
				end
				OP_HSCAN: begin
					if (hit_now)
						hit_q <= ptr_q;
					else if (ptr_q == LAST)
						ptr_q <= LAST;
					else
						ptr_q <= ptr_q + IW'(1);
				end
				OP_VSCAN: begin
					if (users_q[vent] == '0 && (!found_q || age_q[vent] < best_q)) begin
						found_q <= 1'b1;
						best_q <= age_q[vent];
						vpos_q <= ptr_q;
						hit_q <= vent;
					end
					if (ptr_q != '0)
						ptr_q <= ptr_q - IW'(1);
					else
						ptr_q <= vpos_q;
					if (ptr_q == '0 && !(users_q[vent] == '0
							&& (!found_q || age_q[vent] < best_q)))
						ptr_q <= vpos_q;
					else if (ptr_q == '0)
						ptr_q <= ptr_q;
				end
				OP_REMOVE: begin
					// victim entry number held in hit_q; close the gap
					if (found_q) begin
						if (ptr_q != LAST) begin
							order_q[ptr_q] <= order_q[ptr_q + IW'(1)];
							ptr_q <= ptr_q + IW'(1);
						end else begin
							ptr_q <= '0;
							key_q[hit_q] <= rkey_q;
							users_q[hit_q] <= USERS_W'(1);
							span_q[hit_q] <= '0;
						end
					end
				end
				OP_FIND: begin
					if (stat.find_done) begin
						ins_q <= after_now ? ptr_q : LAST;
						ptr_q <= LAST;
					end else
						ptr_q <= ptr_q + IW'(1);
				end
				OP_INSERT: begin
					if (ptr_q != ins_q) begin
						order_q[ptr_q] <= order_q[ptr_q - IW'(1)];
						ptr_q <= ptr_q - IW'(1);
					end else begin
						order_q[ins_q] <= hit_q;
						if (ins_q != LAST && span_q[order_q[ins_q]] != '0)
							span_q[hit_q] <= clip(rkey_q, key_q[order_q[ins_q]]);
						else
							span_q[hit_q] <= SPAN_MAX;
						if (ins_q != '0 && span_q[order_q[ins_q - IW'(1)]] != '0
								&& clip(key_q[order_q[ins_q - IW'(1)]], rkey_q)
								< span_q[order_q[ins_q - IW'(1)]])
							span_q[order_q[ins_q - IW'(1)]]
								<= clip(key_q[order_q[ins_q - IW'(1)]], rkey_q);
						loaded_q[hit_q] <= LW'(1);
						age_q[hit_q] <= age_nx;
						age_ctr_q <= age_nx;
					end
				end
				OP_FINISH: begin
					if (cmd_q == CMD_GET && status_q == ST_HIT) begin
						loaded_q[hent][hsub] <= 1'b1;
						if (users_q[hent] != USERS_MAX)
							users_q[hent] <= users_q[hent] + USERS_W'(1);
						age_q[hent] <= age_nx;
						age_ctr_q <= age_nx;
					end
				end
				OP_CMDCOUNT: begin
					if (slot_ok && cmd_q == CMD_RELEASE && users_q[sidx] != '0)
						users_q[sidx] <= users_q[sidx] - USERS_W'(1);
					else if (slot_ok && cmd_q == CMD_PIN && users_q[sidx] != USERS_MAX)
						users_q[sidx] <= users_q[sidx] + USERS_W'(1);
				end
				default: ;
			endcase
		end
	end

	// request and result registers
	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_LATCH: begin
				cmd_q <= in_command;
				rkey_q <= {in_device, in_block_number};
				slot_q <= in_slot;
				status_q <= ST_FULL;
			end
			OP_HSCAN: if (hit_now) status_q <= ST_HIT;
			OP_FINISH: begin
				if (status_q == ST_HIT) begin
					res_st_q <= ST_HIT;
					id_q <= ID_W'(hent);
					sub_q <= SUB_W'(hsub);
					rd_q <= !loaded_q[hent][hsub];
				end else if (found_q) begin
					res_st_q <= ST_ALLOC;
					id_q <= ID_W'(hit_q);
					sub_q <= '0;
					rd_q <= 1'b1;
				end else begin
					res_st_q <= ST_FULL;
					id_q <= '0;
					sub_q <= '0;
					rd_q <= 1'b0;
				end
			end
			OP_CMDCOUNT: begin
				if (cmd_q == CMD_GET || !slot_ok || (cmd_q != CMD_RELEASE && cmd_q != CMD_PIN)
						|| (cmd_q == CMD_RELEASE && users_q[sidx] == '0))
					res_st_q <= ST_UNDER;
				else
					res_st_q <= ST_COUNT;
				id_q <= slot_q;
				sub_q <= '0;
				rd_q <= 1'b0;
			end
			default: ;
		endcase
	end

	assign status = res_st_q;
	assign entry_id = id_q;
	assign sub_index = sub_q;
	assign needs_read = rd_q;
endmodule

### src/range_keyed_block_cache_core.sv
`timescale 1ns / 1ps
// Range keyed block cache tag store, top level.
// Release/pin: straight to the result. Get: hit scan; on a miss, LRU scan,
// removal, find and insert (find and insert only when a victim is found).
// One beat in flight at a time; the next beat is taken after the result.
// Reset clears all entries, order to identity, age counter to zero at once.
`include "assert_macros.svh"
module range_keyed_block_cache_core import rkbc_pkg::*; #(
	parameter int ENTRY_COUNT = ENTRY_COUNT_DEF,
	parameter int BLOCKS_PER_ENTRY = BLOCKS_PER_ENTRY_DEF
) (
	input logic clk,
	input logic arst_n,
	rkbc_in_if.sink in_ch,
	rkbc_out_if.source out_ch
);
	dp_cmd_t cmd;
	dp_stat_t stat;

	// controller sequences hit scan, victim scan, removal, find, insert
	rkbc_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_command(in_ch.command),
		.out_valid(out_ch.valid), .out_ready(out_ch.ready),
		.cmd(cmd), .stat(stat)
	);

	rkbc_dp #(.ENTRY_COUNT(ENTRY_COUNT), .BLOCKS_PER_ENTRY(BLOCKS_PER_ENTRY)) u_dp (
		.clk(clk), .arst_n(arst_n),
		.in_command(in_ch.command), .in_device(in_ch.device),
		.in_block_number(in_ch.block_number), .in_slot(in_ch.slot),
		.cmd(cmd), .stat(stat),
		.status(out_ch.status), .entry_id(out_ch.entry_id),
		.sub_index(out_ch.sub_index), .needs_read(out_ch.needs_read)
	);

	`RKB_ASSERT(a_no_accept_busy, clk, arst_n, (in_ch.valid && in_ch.ready) |=> !in_ch.ready, "beat accepted while busy")
	`RKB_ASSERT(a_out_hold, clk, arst_n, (out_ch.valid && !out_ch.ready) |=> out_ch.valid, "result dropped")
	`RKB_ASSERT_ALWAYS(a_rst_idle, clk, !arst_n |=> !out_ch.valid, "valid in reset")
endmodule
